// ===== design/idll_pkg.sv =====
// Shared types and codes for the indexed doubly linked list.
package idll_pkg;

    localparam int ID_W     = 6;
    localparam int ID_DEPTH = 1 << ID_W;

    typedef logic [ID_W-1:0] t_id;
    typedef logic [1:0]      t_opcode;

    localparam t_opcode OP_INSERT = 2'd0;
    localparam t_opcode OP_REMOVE = 2'd1;
    localparam t_opcode OP_EMIT   = 2'd2;

    // Slave-side item as packed in tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic    pad;
        logic    side;
        t_id     anchor_id;
        t_id     node_id;
        t_opcode opcode;
    } t_in_item;

endpackage

// ===== design/indexed_doubly_linked_list.sv =====
// Top level of the indexed doubly linked list: controller, link memories and output stage.
//
// This block keeps an ordered list of node ids 1..MAX_NODES, with id 0 as nil, in two
// link memories (left and right neighbor of every id), a head register and one presence
// flip-flop per id. After reset only node 1 is listed. An insert item places a new id
// directly left or right of a present anchor; an insert with an out-of-range or already
// present id, or with an absent anchor, is dropped. A remove item unlinks a present id
// and drops an absent one; removing the only node empties the list. Neither gives a
// result. An emit item walks from the head and gives one result item per node in order,
// with tlast on the final one, or a single item with id 0, tlast and tuser set when the
// list is empty; the walk stops after MAX_NODES results. Opcode three is dropped. The
// block works on one item at a time. In a valid insert or remove the accept cycle
// reads both link memories, then states S_W1 and S_W2 write back, because each link
// memory has one write port and an insert or remove touches two entries of each. A
// dropped item leaves the block idle. An emit reads the head's links at accept and
// then steps from node to node through the right-link read that each step of the walk
// needs; an empty emit goes out through S_EMPTY. A stalled master side holds the walk.
// The link memories need no clearing pass: a written flag per entry makes unwritten
// entries read as nil, and the block accepts items as soon as reset is released.
module indexed_doubly_linked_list
    import idll_pkg::*;
#(
    parameter int MAX_NODES = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side. tdata: opcode[1:0], node_id[7:2], anchor_id[13:8], side[14], zero[15].
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    // Master side. tdata: node_id_res[5:0], zero[7:6]. tlast: last. tuser: empty_res.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tuser
);

    // Controller states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_W1    = 3'd1;
    localparam logic [2:0] S_W2    = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_EMPTY = 3'd4;

    localparam t_id ID_MAX  = ID_W'(MAX_NODES);
    localparam t_id CNT_END = ID_W'(MAX_NODES - 1);
    localparam t_id ID_NIL  = '0;

    t_in_item in_item;

    logic [2:0]          r_state, n_state;
    logic                r_is_remove, n_is_remove;
    t_id                 r_id, n_id;
    t_id                 r_anchor, n_anchor;
    logic                r_side, n_side;
    t_id                 r_head, n_head;
    t_id                 r_cur, n_cur;
    t_id                 r_cnt, n_cnt;
    logic [ID_DEPTH-1:0] r_present, n_present;

    // Written flags of the link memories; an entry never written reads as nil.
    logic [ID_DEPTH-1:0] r_lwr, r_rwr;
    logic                r_lwr_rd, r_rwr_rd;

    logic                r_m_valid, n_m_valid;
    t_id                 r_m_id, n_m_id;
    logic                r_m_last, n_m_last;
    logic                r_m_empty, n_m_empty;

    // Link memory ports.
    logic l_we, rt_we, rd_en;
    t_id  l_waddr, l_wdata, rt_waddr, rt_wdata, rd_addr;
    t_id  l_rdata, rt_rdata, l_link, rt_link;

    logic accept, out_free;
    logic id_ok, anc_ok, ins_ok, rem_ok;
    logic walk_last;

    assign in_item    = t_in_item'(i_s_tdata);
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    assign l_link  = r_lwr_rd ? l_rdata : ID_NIL;
    assign rt_link = r_rwr_rd ? rt_rdata : ID_NIL;

    // Range and presence checks on the incoming item.
    assign id_ok  = (in_item.node_id != ID_NIL) && (in_item.node_id <= ID_MAX);
    assign anc_ok = (in_item.anchor_id != ID_NIL) && (in_item.anchor_id <= ID_MAX)
                    && r_present[in_item.anchor_id];
    assign ins_ok = id_ok && !r_present[in_item.node_id] && anc_ok;
    assign rem_ok = id_ok && r_present[in_item.node_id];

    assign walk_last = (rt_link == ID_NIL) || (r_cnt == CNT_END);

    always_comb begin
        n_state     = r_state;
        n_is_remove = r_is_remove;
        n_id        = r_id;
        n_anchor    = r_anchor;
        n_side      = r_side;
        n_head      = r_head;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_present   = r_present;
        n_m_valid   = r_m_valid && !i_m_tready;
        n_m_id      = r_m_id;
        n_m_last    = r_m_last;
        n_m_empty   = r_m_empty;
        l_we        = 1'b0;
        l_waddr     = r_id;
        l_wdata     = ID_NIL;
        rt_we       = 1'b0;
        rt_waddr    = r_id;
        rt_wdata    = ID_NIL;
        rd_en       = 1'b0;
        rd_addr     = in_item.anchor_id;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id        = in_item.node_id;
                    n_anchor    = in_item.anchor_id;
                    n_side      = in_item.side;
                    n_is_remove = (in_item.opcode == OP_REMOVE);
                    case (in_item.opcode)
                        OP_INSERT: begin
                            if (ins_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = in_item.anchor_id;
                                n_state = S_W1;
                            end
                        end
                        OP_REMOVE: begin
                            if (rem_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = in_item.node_id;
                                n_state = S_W1;
                            end
                        end
                        OP_EMIT: begin
                            if (r_head == ID_NIL) begin
                                n_state = S_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_cur   = r_head;
                                n_cnt   = ID_NIL;
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_W1: begin
                if (r_is_remove) begin
                    // Bridge the two neighbors of the removed node.
                    if (l_link != ID_NIL) begin
                        rt_we    = 1'b1;
                        rt_waddr = l_link;
                        rt_wdata = rt_link;
                    end else begin
                        n_head = rt_link;
                    end
                    if (rt_link != ID_NIL) begin
                        l_we    = 1'b1;
                        l_waddr = rt_link;
                        l_wdata = l_link;
                    end
                end else begin
                    // Links of the new node: anchor on one side, old neighbor on the other.
                    l_we     = 1'b1;
                    l_waddr  = r_id;
                    rt_we    = 1'b1;
                    rt_waddr = r_id;
                    if (r_side) begin
                        l_wdata  = r_anchor;
                        rt_wdata = rt_link;
                    end else begin
                        l_wdata  = l_link;
                        rt_wdata = r_anchor;
                    end
                end
                n_state = S_W2;
            end
            S_W2: begin
                // The read data still holds the links read at accept (anchor or node).
                if (r_is_remove) begin
                    l_we     = 1'b1;
                    l_waddr  = r_id;
                    rt_we    = 1'b1;
                    rt_waddr = r_id;
                    n_present[r_id] = 1'b0;
                end else begin
                    if (r_side) begin
                        rt_we    = 1'b1;
                        rt_waddr = r_anchor;
                        rt_wdata = r_id;
                        if (rt_link != ID_NIL) begin
                            l_we    = 1'b1;
                            l_waddr = rt_link;
                            l_wdata = r_id;
                        end
                    end else begin
                        l_we    = 1'b1;
                        l_waddr = r_anchor;
                        l_wdata = r_id;
                        if (l_link != ID_NIL) begin
                            rt_we    = 1'b1;
                            rt_waddr = l_link;
                            rt_wdata = r_id;
                        end else begin
                            n_head = r_id;
                        end
                    end
                    n_present[r_id] = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_EMIT: begin
                // rt_link is the right neighbor of r_cur; it holds while the output stalls.
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_id    = r_cur;
                    n_m_last  = walk_last;
                    n_m_empty = 1'b0;
                    if (walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = rt_link;
                        n_cur   = rt_link;
                        n_cnt   = r_cnt + 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_id    = ID_NIL;
                    n_m_last  = 1'b1;
                    n_m_empty = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= ID_W'(1);
            r_present  <= ID_DEPTH'(2);
            r_lwr      <= '0;
            r_rwr      <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_present  <= n_present;
            r_m_valid  <= n_m_valid;
            if (l_we) begin
                r_lwr[l_waddr] <= 1'b1;
            end
            if (rt_we) begin
                r_rwr[rt_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_remove <= n_is_remove;
        r_id        <= n_id;
        r_anchor    <= n_anchor;
        r_side      <= n_side;
        r_cur       <= n_cur;
        r_cnt       <= n_cnt;
        r_m_id      <= n_m_id;
        r_m_last    <= n_m_last;
        r_m_empty   <= n_m_empty;
        if (rd_en) begin
            r_lwr_rd <= r_lwr[rd_addr];
            r_rwr_rd <= r_rwr[rd_addr];
        end
    end

    idll_ram #(
        .WIDTH (ID_W),
        .DEPTH (ID_DEPTH)
    ) u_left_links (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (l_rdata)
    );

    idll_ram #(
        .WIDTH (ID_W),
        .DEPTH (ID_DEPTH)
    ) u_right_links (
        .i_clk   (i_clk),
        .i_we    (rt_we),
        .i_waddr (rt_waddr),
        .i_wdata (rt_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rt_rdata)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_m_id};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_empty;

`ifndef SYNTH
    // A nonzero head always names a listed node.
    a_head_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != ID_NIL) |-> r_present[r_head])
        else $error("head register names a node that is not present");

    // Between items, an empty list has no presence bit set, nil included.
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_head == ID_NIL)) |-> (r_present == '0) && !r_present[0])
        else $error("list is empty but presence bits remain set");

    // The walk only ever visits listed nodes.
    a_walk_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_present[r_cur])
        else $error("emit walk reached a node that is not present");
`endif

endmodule

// ===== design/idll_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
module idll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // The read data holds its value until the next enabled read.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
